[hw/rtl/assert_macros.svh]
// Assertion macros shared by the endpointer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/vae_pkg.sv]
// Shared types and constants of the voice activity endpointer.
package vae_pkg;

    localparam int ENERGY_W   = 40;
    localparam int SILENCE_W  = 16;
    localparam int HOP_W      = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;

    localparam logic [ENERGY_W-1:0]  ENERGY_MAX  = {ENERGY_W{1'b1}};
    localparam logic [SILENCE_W-1:0] SILENCE_MAX = {SILENCE_W{1'b1}};

    // Register reset values
    localparam logic                 RST_DETECT_ENABLE    = 1'b1;
    localparam logic [ENERGY_W-1:0]  RST_ENERGY_THRESHOLD = 40'd5497558139;
    localparam logic [SILENCE_W-1:0] RST_SILENCE_LIMIT    = 16'd50;
    localparam logic [HOP_W-1:0]     RST_HOP_LENGTH       = 10'd160;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_ENABLE    = 8'd0,
        CFG_ENERGY_THRESHOLD = 8'd1,
        CFG_SILENCE_LIMIT    = 8'd2,
        CFG_HOP_LENGTH       = 8'd3
    } t_cfg_index;

    typedef struct packed {
        logic                 detect_enable;
        logic [ENERGY_W-1:0]  energy_threshold;
        logic [SILENCE_W-1:0] silence_limit;
        logic [HOP_W-1:0]     hop_length;
    } t_cfg;

    // Valid and window-close flag carried down the pipe
    typedef struct packed {
        logic vld;
        logic judge;
    } t_stage_ctl;

endpackage

[hw/rtl/voice_activity_endpointer.sv]
// Top level of the energy-based voice activity endpointer.
//
//  channel  | direction | handshake                        | payload
//  ---------+-----------+----------------------------------+----------------------------------
//  sample   | in        | i_sample_valid / o_sample_ready  | i_sample
//  result   | out       | o_result_valid / i_result_ready  | o_voiced, o_utterance_end,
//           |           |                                  | o_frame_energy, o_silent_windows
//  config   | in        | i_cfg_valid / o_cfg_ready        | i_cfg_index, i_cfg_data
//
// One sample request per cycle while o_sample_ready is high; a result passes s1, s2, s3 and the result register.
// The ring RAM port (read-old, write-new at one address) sets the one-cycle rate.
// Reset needs no ring clearing pass: the fill count masks entries not yet written.
// A stalled result holds its register while up to three more samples queue in the pipe.
// Config requests are always taken and expected only while the block is idle.
`include "assert_macros.svh"
module voice_activity_endpointer #(
    parameter int WINDOW_SAMPLES = 512,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_sample_valid,
    output logic                               o_sample_ready,
    input  logic [SAMPLE_BITS-1:0]             i_sample,
    output logic                               o_result_valid,
    input  logic                               i_result_ready,
    output logic                               o_voiced,
    output logic                               o_utterance_end,
    output logic [vae_pkg::ENERGY_W-1:0]       o_frame_energy,
    output logic [vae_pkg::SILENCE_W-1:0]      o_silent_windows,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vae_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vae_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import vae_pkg::*;

    localparam int ENERGY_SUM_W = $clog2(WINDOW_SAMPLES) + 2 * SAMPLE_BITS - 1;

    t_cfg                    r_cfg;
    t_stage_ctl              s3_ctl;
    logic [ENERGY_SUM_W-1:0] s3_energy;
    logic                    s3_leave;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_enable    <= RST_DETECT_ENABLE;
            r_cfg.energy_threshold <= RST_ENERGY_THRESHOLD;
            r_cfg.silence_limit    <= RST_SILENCE_LIMIT;
            r_cfg.hop_length       <= RST_HOP_LENGTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DETECT_ENABLE: begin
                    r_cfg.detect_enable <= i_cfg_data[0];
                end
                CFG_ENERGY_THRESHOLD: begin
                    r_cfg.energy_threshold <= i_cfg_data[ENERGY_W-1:0];
                end
                CFG_SILENCE_LIMIT: begin
                    r_cfg.silence_limit <= i_cfg_data[SILENCE_W-1:0];
                end
                CFG_HOP_LENGTH: begin
                    r_cfg.hop_length <= i_cfg_data[HOP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    vae_front #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .ENERGY_SUM_W   (ENERGY_SUM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hop_length (r_cfg.hop_length),
        .i_valid      (i_sample_valid),
        .o_ready      (o_sample_ready),
        .i_sample     (i_sample),
        .i_s3_leave   (s3_leave),
        .o_s3         (s3_ctl),
        .o_energy     (s3_energy)
    );

    vae_decide #(
        .ENERGY_SUM_W (ENERGY_SUM_W)
    ) u_decide (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_s3             (s3_ctl),
        .i_energy         (s3_energy),
        .o_s3_leave       (s3_leave),
        .o_valid          (o_result_valid),
        .i_ready          (i_result_ready),
        .o_voiced         (o_voiced),
        .o_utterance_end  (o_utterance_end),
        .o_frame_energy   (o_frame_energy),
        .o_silent_windows (o_silent_windows)
    );

    // A stalled result keeps the pipe from losing a closed window
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_result_valid && !i_result_ready,
        o_result_valid)

endmodule

[hw/rtl/vae_ram.sv]
// Generic single-write, single-read RAM with registered read-first output.
module vae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/vae_front.sv]
// Sample ring, window/hop counters, squaring and running energy sum.
`include "assert_macros.svh"
module vae_front #(
    parameter int WINDOW_SAMPLES = 512,
    parameter int SAMPLE_BITS    = 16,
    parameter int ENERGY_SUM_W   = 40
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [vae_pkg::HOP_W-1:0]  i_hop_length,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [SAMPLE_BITS-1:0]     i_sample,
    input  logic                       i_s3_leave,
    output vae_pkg::t_stage_ctl        o_s3,
    output logic [ENERGY_SUM_W-1:0]    o_energy
);
    import vae_pkg::*;

    localparam int POS_W  = $clog2(WINDOW_SAMPLES);
    localparam int FILL_W = $clog2(WINDOW_SAMPLES + 1);
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_SAMPLES);
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW_SAMPLES - 1);

    logic [POS_W-1:0]        r_pos, n_pos;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [HOP_W-1:0]        r_hop, n_hop;
    t_stage_ctl              r_s1, r_s2, r_s3;
    logic                    r_s1_full;
    logic [SAMPLE_BITS-1:0]  r_s1_sample;
    logic [SQ_W-1:0]         r_s2_sq_new, r_s2_sq_old;
    logic [ENERGY_SUM_W-1:0] r_energy, n_energy;

    logic                    s1_free, s2_free, s3_free, accept;
    logic                    full, judge_n;
    logic [FILL_W-1:0]       fill_inc;
    logic [HOP_W-1:0]        hop_inc, hop_eff;
    logic [SAMPLE_BITS-1:0]  old_raw, old_sample;
    logic [2*SAMPLE_BITS-1:0] prod_new, prod_old;

    // Bubble-collapsing pipe: a stage takes data when empty or draining
    assign s3_free = !r_s3.vld || i_s3_leave;
    assign s2_free = !r_s2.vld || s3_free;
    assign s1_free = !r_s1.vld || s2_free;
    assign o_ready = s1_free;
    assign accept  = i_valid && s1_free;

    // Window and hop bookkeeping at request accept
    always_comb begin
        full     = (r_fill == FILL_FULL);
        fill_inc = r_fill + 1'b1;
        hop_inc  = r_hop + 1'b1;
        hop_eff  = (i_hop_length == '0) ? HOP_W'(1) : i_hop_length;
        n_pos    = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
        if (!full) begin
            n_fill  = fill_inc;
            judge_n = (fill_inc == FILL_FULL);
            n_hop   = judge_n ? '0 : r_hop;
        end else begin
            n_fill  = r_fill;
            judge_n = (hop_inc >= hop_eff);
            n_hop   = judge_n ? '0 : hop_inc;
        end
    end

    // Ring store; the entry leaving the window is read as it is overwritten
    vae_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_SAMPLES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_pos),
        .i_wdata (i_sample),
        .i_re    (accept),
        .i_raddr (r_pos),
        .o_rdata (old_raw)
    );

    // Entries not yet written stand for the zero reset contents
    assign old_sample = r_s1_full ? old_raw : '0;
    assign prod_new   = $signed(r_s1_sample) * $signed(r_s1_sample);
    assign prod_old   = $signed(old_sample) * $signed(old_sample);

    // Running sum update: drop the leaving square, add the new one
    assign n_energy = r_energy - ENERGY_SUM_W'(r_s2_sq_old) + ENERGY_SUM_W'(r_s2_sq_new);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_fill   <= '0;
            r_hop    <= '0;
            r_s1     <= '0;
            r_s2     <= '0;
            r_s3     <= '0;
            r_energy <= '0;
        end else begin
            if (accept) begin
                r_pos  <= n_pos;
                r_fill <= n_fill;
                r_hop  <= n_hop;
            end
            if (s1_free) begin
                r_s1.vld   <= accept;
                r_s1.judge <= judge_n;
            end
            if (s2_free) begin
                r_s2 <= r_s1;
            end
            if (s3_free) begin
                r_s3 <= r_s2;
                if (r_s2.vld) begin
                    r_energy <= n_energy;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_full   <= full;
            r_s1_sample <= i_sample;
        end
        if (s2_free && r_s1.vld) begin
            r_s2_sq_new <= prod_new[SQ_W-1:0];
            r_s2_sq_old <= prod_old[SQ_W-1:0];
        end
    end

    assign o_s3     = r_s3;
    assign o_energy = r_energy;

    // Before the ring fills, the write position equals the fill count
    `ASSERT_IMPLIES(a_pos_tracks_fill, i_clk, i_rst_n, r_fill < FILL_FULL,
        r_pos == r_fill[POS_W-1:0])
    // The first window closes exactly as the ring becomes full
    `ASSERT_IMPLIES(a_first_window, i_clk, i_rst_n, r_s1.vld && r_s1.judge && !r_s1_full,
        r_fill == FILL_FULL)

endmodule

[hw/rtl/vae_decide.sv]
// Threshold decision, silence counting and result register.
`include "assert_macros.svh"
module vae_decide #(
    parameter int ENERGY_SUM_W = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vae_pkg::t_cfg                     i_cfg,
    input  vae_pkg::t_stage_ctl               i_s3,
    input  logic [ENERGY_SUM_W-1:0]           i_energy,
    output logic                              o_s3_leave,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_voiced,
    output logic                              o_utterance_end,
    output logic [vae_pkg::ENERGY_W-1:0]      o_frame_energy,
    output logic [vae_pkg::SILENCE_W-1:0]     o_silent_windows
);
    import vae_pkg::*;

    localparam int CMP_W = (ENERGY_SUM_W > ENERGY_W) ? ENERGY_SUM_W : ENERGY_W;

    logic                 r_o_vld;
    logic                 r_o_voiced, r_o_end;
    logic [ENERGY_W-1:0]  r_o_energy;
    logic [SILENCE_W-1:0] r_silence, n_silence;
    logic                 r_utt_open, n_utt_open;

    logic                 out_free, take, voiced, ended;
    logic [CMP_W-1:0]     energy_ext;
    logic [ENERGY_W-1:0]  energy_sat;

    // Result register frees when empty or being taken
    assign out_free   = !r_o_vld || i_ready;
    assign o_s3_leave = !i_s3.judge || out_free;
    assign take       = i_s3.vld && i_s3.judge && out_free;

    // Window decision and silence bookkeeping
    always_comb begin
        energy_ext = CMP_W'(i_energy);
        energy_sat = (energy_ext > CMP_W'(ENERGY_MAX)) ? ENERGY_MAX
                                                       : energy_ext[ENERGY_W-1:0];
        voiced     = !i_cfg.detect_enable
                     || (energy_ext > CMP_W'(i_cfg.energy_threshold));
        ended      = 1'b0;
        n_utt_open = r_utt_open;
        if (voiced) begin
            n_silence  = '0;
            n_utt_open = 1'b1;
        end else begin
            n_silence = (r_silence == SILENCE_MAX) ? r_silence : r_silence + 1'b1;
            if ((n_silence > i_cfg.silence_limit) && r_utt_open) begin
                ended      = 1'b1;
                n_utt_open = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld    <= 1'b0;
            r_silence  <= '0;
            r_utt_open <= 1'b0;
        end else begin
            if (out_free) begin
                r_o_vld <= take;
            end
            if (take) begin
                r_silence  <= n_silence;
                r_utt_open <= n_utt_open;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_voiced <= voiced;
            r_o_end    <= ended;
            r_o_energy <= energy_sat;
        end
    end

    assign o_valid          = r_o_vld;
    assign o_voiced         = r_o_voiced;
    assign o_utterance_end  = r_o_end;
    assign o_frame_energy   = r_o_energy;
    assign o_silent_windows = r_silence;

    // An end flag closes the utterance and never comes with speech
    `ASSERT_IMPLIES(a_end_closes, i_clk, i_rst_n, r_o_vld && r_o_end,
        !r_o_voiced && !r_utt_open)
    // A voiced window clears the count and leaves an utterance open
    `ASSERT_IMPLIES(a_voiced_clears, i_clk, i_rst_n, r_o_vld && r_o_voiced,
        (r_silence == '0) && r_utt_open)

endmodule
